/* sv/assert_macros.svh */
// assertion macros shared by the rtl files
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked out of reset
`define FEP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define FEP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FEP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fep_pkg.sv */
// types, codes and defaults of the foreground edge profiler
// no dependencies
`default_nettype none

package fep_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam logic [7:0]  WHITE_LEVEL_RST  = 8'd250;
  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [10:0] FRAME_HEIGHT_RST = 11'd1024;

  // request and result codes
  localparam logic REQ_PIXEL   = 1'b0;
  localparam logic REQ_READ    = 1'b1;
  localparam logic KIND_ROW    = 1'b0;
  localparam logic KIND_COLUMN = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] column_index;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [9:0]  line_index;
    logic [10:0] first_edge;
    logic [10:0] last_edge;
    logic [10:0] least_left;
    logic [10:0] greatest_right;
    logic [10:0] least_top;
    logic [10:0] greatest_bottom;
    logic        frame_done;
  } out_t;

endpackage

`default_nettype wire

/* sv/fep_col_store.sv */
// per-column top/bottom store: one write port, one registered read port
// write-to-read bypass for a read issued at the edge of a write to the same column
`default_nettype none

module fep_col_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 22
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [DW-1:0] wr_data_i,
  output logic      [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] mem_rd_q;
  logic [DW-1:0] byp_data_q;
  logic          byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      mem_rd_q   <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : mem_rd_q;

endmodule

`default_nettype wire

/* sv/foreground_edge_profile_top.sv */
// input words are held in the stage register, result words in the output register
// throughput: one word per cycle barring output stalls; column store read-modify-write
// is split: accept edge reads, stage edge writes, with bypass between them
// reset: control, raster position, row extents and frame extremes clear; config
// goes to white level 250 and 1024 x 1024; column store contents stay undefined
`default_nettype none

`include "assert_macros.svh"

module foreground_edge_profile_top #(
  parameter int MAX_WIDTH  = fep_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fep_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // pixel / read request channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire fep_pkg::in_t                    in_data_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output fep_pkg::out_t                        out_data_o,
  // configuration writes
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [fep_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [fep_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import fep_pkg::*;

  // index widths for x/y, position widths (1-based, up to the maximum)
  localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PXW = $clog2(MAX_WIDTH + 1);
  localparam int PYW = $clog2(MAX_HEIGHT + 1);
  // compare widths for clamping the 11-bit geometry registers
  localparam int EXW = (PXW > CFG_DATA_W) ? PXW : CFG_DATA_W;
  localparam int EYW = (PYW > CFG_DATA_W) ? PYW : CFG_DATA_W;
  localparam int DW  = 2 * PYW;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]            white_level_q;
  logic [CFG_DATA_W-1:0] frame_width_q;
  logic [CFG_DATA_W-1:0] frame_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_level_q  <= WHITE_LEVEL_RST;
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WHITE_LEVEL:  white_level_q  <= cfg_data_i[7:0];
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // effective geometry: zero acts as one, above the maximum acts as the maximum
  logic [EXW-1:0] fw_e, w_e;
  logic [EYW-1:0] fh_e, h_e;
  logic [PXW-1:0] w_eff;
  logic [PYW-1:0] h_eff;

  always_comb begin
    fw_e = EXW'(frame_width_q);
    fh_e = EYW'(frame_height_q);
    if (fw_e == '0) begin
      w_e = EXW'(1);
    end else if (fw_e > EXW'(MAX_WIDTH)) begin
      w_e = EXW'(MAX_WIDTH);
    end else begin
      w_e = fw_e;
    end
    if (fh_e == '0) begin
      h_e = EYW'(1);
    end else if (fh_e > EYW'(MAX_HEIGHT)) begin
      h_e = EYW'(MAX_HEIGHT);
    end else begin
      h_e = fh_e;
    end
    w_eff = PXW'(w_e);
    h_eff = PYW'(h_e);
  end

  // ---------------------------------------------------------------------------
  // handshake and stage control
  // ---------------------------------------------------------------------------
  logic s1_valid_q;
  logic s1_emit;
  logic s1_go;
  logic out_valid_q;
  logic out_free;
  logic in_acc;

  // output slot can take a word this cycle if empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  // a stage word without a result never waits on the output side
  assign s1_go      = s1_valid_q && (out_free || !s1_emit);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // accept side: raster position, foreground test, store read address
  // ---------------------------------------------------------------------------
  logic [XW-1:0]  pixel_x_q;
  logic [YW-1:0]  pixel_y_q;
  logic [PXW-1:0] px_e, x_c, pos_x;
  logic [PYW-1:0] py_e, y_c, pos_y;
  logic           row_end, done, fg, is_pixel, col_oob;
  logic [XW-1:0]  rd_addr;

  always_comb begin
    is_pixel = (in_data_i.req_type == REQ_PIXEL);
    px_e     = PXW'(pixel_x_q);
    py_e     = PYW'(pixel_y_q);
    // position beyond a shrunk geometry clamps to the last column / row
    x_c      = (px_e >= w_eff) ? w_eff - PXW'(1) : px_e;
    y_c      = (py_e >= h_eff) ? h_eff - PYW'(1) : py_e;
    pos_x    = x_c + PXW'(1);
    pos_y    = y_c + PYW'(1);
    row_end  = (pos_x >= w_eff);
    done     = (pos_y >= h_eff);
    fg       = (in_data_i.red <= white_level_q) ||
               (in_data_i.green <= white_level_q) ||
               (in_data_i.blue <= white_level_q);
    col_oob  = (32'(in_data_i.column_index) >= 32'(MAX_WIDTH));
    rd_addr  = is_pixel ? XW'(x_c) : XW'(in_data_i.column_index);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_x_q <= '0;
      pixel_y_q <= '0;
    end else if (in_acc && is_pixel) begin
      if (row_end) begin
        pixel_x_q <= '0;
        pixel_y_q <= done ? '0 : YW'(pos_y);
      end else begin
        pixel_x_q <= XW'(pos_x);
        pixel_y_q <= YW'(y_c);
      end
    end
  end

  // stage register payload
  logic           s1_kind;
  logic [9:0]     s1_col;
  logic           s1_col_oob;
  logic [XW-1:0]  s1_x;
  logic [YW-1:0]  s1_y;
  logic [PXW-1:0] s1_pos_x;
  logic [PYW-1:0] s1_pos_y;
  logic           s1_fg;
  logic           s1_row_end;
  logic           s1_done;
  logic           s1_frame_start;
  logic           s1_row_start;
  logic           s1_first_row;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind        <= is_pixel ? KIND_ROW : KIND_COLUMN;
      s1_col         <= in_data_i.column_index;
      s1_col_oob     <= col_oob;
      s1_x           <= XW'(x_c);
      s1_y           <= YW'(y_c);
      s1_pos_x       <= pos_x;
      s1_pos_y       <= pos_y;
      s1_fg          <= fg;
      s1_row_end     <= row_end;
      s1_done        <= done;
      s1_frame_start <= (x_c == '0) && (y_c == '0);
      s1_row_start   <= (x_c == '0);
      s1_first_row   <= (y_c == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // column store
  // ---------------------------------------------------------------------------
  logic [DW-1:0]  st_rd_data;
  logic [DW-1:0]  st_wr_data;
  logic           st_wr_en;
  logic [PYW-1:0] top_old, bot_old, top_new, bot_new;

  fep_col_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (XW),
    .DW    (DW)
  ) u_col_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (rd_addr),
    .wr_en_i   (st_wr_en),
    .wr_addr_i (s1_x),
    .wr_data_i (st_wr_data),
    .rd_data_o (st_rd_data)
  );

  assign top_old = st_rd_data[DW-1:PYW];
  assign bot_old = st_rd_data[PYW-1:0];

  // ---------------------------------------------------------------------------
  // stage logic: row extents, frame extremes, store update, result word
  // ---------------------------------------------------------------------------
  logic [PXW-1:0] row_first_q, row_last_q;
  logic [PXW-1:0] least_left_q, greatest_right_q;
  logic [PYW-1:0] least_top_q, greatest_bottom_q;

  logic [PXW-1:0] rf_base, rl_base, ll_base, gr_base;
  logic [PYW-1:0] lt_base, gb_base;
  logic [PXW-1:0] rf_n, rl_n, ll_n, gr_n;
  logic [PYW-1:0] lt_n, gb_n;
  logic           s1_pixel;
  out_t           res;

  always_comb begin
    s1_pixel = (s1_kind == KIND_ROW);
    s1_emit  = !s1_pixel || s1_row_end;

    // row start clears row extents, frame start clears frame extremes
    rf_base = s1_row_start ? '0 : row_first_q;
    rl_base = s1_row_start ? '0 : row_last_q;
    ll_base = s1_frame_start ? '0 : least_left_q;
    gr_base = s1_frame_start ? '0 : greatest_right_q;
    lt_base = s1_frame_start ? '0 : least_top_q;
    gb_base = s1_frame_start ? '0 : greatest_bottom_q;

    rf_n = (s1_fg && (rf_base == '0)) ? s1_pos_x : rf_base;
    rl_n = s1_fg ? s1_pos_x : rl_base;
    lt_n = (s1_fg && ((lt_base == '0) || (s1_pos_y < lt_base))) ? s1_pos_y : lt_base;
    gb_n = (s1_fg && (s1_pos_y > gb_base)) ? s1_pos_y : gb_base;
    ll_n = ll_base;
    gr_n = gr_base;
    if (s1_row_end) begin
      if ((rf_n != '0) && ((ll_base == '0) || (rf_n < ll_base))) begin
        ll_n = rf_n;
      end
      if (rl_n > gr_base) begin
        gr_n = rl_n;
      end
    end

    // first row overwrites, later rows only record foreground
    if (s1_first_row) begin
      top_new = s1_fg ? s1_pos_y : '0;
      bot_new = s1_fg ? s1_pos_y : '0;
    end else begin
      top_new = (top_old == '0) ? s1_pos_y : top_old;
      bot_new = s1_pos_y;
    end
    st_wr_en   = s1_go && s1_pixel && (s1_first_row || s1_fg);
    st_wr_data = {top_new, bot_new};

    res.result_kind = s1_kind;
    if (s1_pixel) begin
      res.line_index      = 10'(s1_y);
      res.first_edge      = 11'(rf_n);
      res.last_edge       = 11'(rl_n);
      res.least_left      = 11'(ll_n);
      res.greatest_right  = 11'(gr_n);
      res.least_top       = 11'(lt_n);
      res.greatest_bottom = 11'(gb_n);
      res.frame_done      = s1_done;
    end else begin
      // column read: state untouched, reports extremes as they stand
      res.line_index      = s1_col;
      res.first_edge      = s1_col_oob ? '0 : 11'(top_old);
      res.last_edge       = s1_col_oob ? '0 : 11'(bot_old);
      res.least_left      = 11'(least_left_q);
      res.greatest_right  = 11'(greatest_right_q);
      res.least_top       = 11'(least_top_q);
      res.greatest_bottom = 11'(greatest_bottom_q);
      res.frame_done      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_first_q       <= '0;
      row_last_q        <= '0;
      least_left_q      <= '0;
      greatest_right_q  <= '0;
      least_top_q       <= '0;
      greatest_bottom_q <= '0;
    end else if (s1_go && s1_pixel) begin
      row_first_q       <= rf_n;
      row_last_q        <= rl_n;
      least_left_q      <= ll_n;
      greatest_right_q  <= gr_n;
      least_top_q       <= lt_n;
      greatest_bottom_q <= gb_n;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  out_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_emit) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `FEP_ASSERT_IMP(a_no_stall_empty, !s1_valid_q, !in_stall_o,
                  "input stalled with empty stage")
  `FEP_ASSERT_IMP(a_emit_has_slot, s1_go && s1_emit, out_free,
                  "result moved into an occupied output slot")
  `FEP_ASSERT_NXT(a_row_end_wraps, in_acc && is_pixel && row_end, pixel_x_q == '0,
                  "raster x did not wrap at row end")
  `FEP_ASSERT(a_done_only_rows,
              !(out_valid_o && out_data_o.frame_done &&
                (out_data_o.result_kind == KIND_COLUMN)),
              "frame done flagged on a column read")

endmodule

`default_nettype wire

/* tb/edge_profile_checker.sv */
// checker for the foreground edge profiler: follows config, pixel and read words,
// predicts every row and column profile word and compares it with the result channel
// depends on fep_pkg
`timescale 1ns / 100ps

module edge_profile_checker
  import fep_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_t                   in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_t                  out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  logic [7:0]  white_level;
  logic [10:0] frame_width;
  logic [10:0] frame_height;
  int unsigned raster_x;
  int unsigned raster_y;
  logic [10:0] row_first;
  logic [10:0] row_last;
  logic [10:0] col_top [MAX_WIDTH];
  logic [10:0] col_bottom [MAX_WIDTH];
  logic [10:0] least_left;
  logic [10:0] greatest_right;
  logic [10:0] least_top;
  logic [10:0] greatest_bottom;
  out_t        profiles_due [$];
  int          reported;

  function automatic int unsigned clamp_dim(input logic [10:0] v, input int unsigned lim);
    if (v == '0) return 1;
    if (32'(v) > lim) return lim;
    return 32'(v);
  endfunction

  function automatic out_t profile_word(input logic kind, input int unsigned line,
                                        input logic [10:0] first, input logic [10:0] last,
                                        input logic done);
    out_t r;
    r.result_kind     = kind;
    r.line_index      = 10'(line);
    r.first_edge      = first;
    r.last_edge       = last;
    r.least_left      = least_left;
    r.greatest_right  = greatest_right;
    r.least_top       = least_top;
    r.greatest_bottom = greatest_bottom;
    r.frame_done      = done;
    return r;
  endfunction

  function automatic string show(input out_t r);
    return $sformatf("kind %0d line %0d edges %0d..%0d left %0d right %0d top %0d bot %0d done %0d",
                     r.result_kind, r.line_index, r.first_edge, r.last_edge, r.least_left,
                     r.greatest_right, r.least_top, r.greatest_bottom, r.frame_done);
  endfunction

  task automatic take_pixel(input in_t w);
    int unsigned wd, ht, x, y, pos_x, pos_y;
    logic        fg;
    wd    = clamp_dim(frame_width, MAX_WIDTH);
    ht    = clamp_dim(frame_height, MAX_HEIGHT);
    x     = (raster_x >= wd) ? wd - 1 : raster_x;
    y     = (raster_y >= ht) ? ht - 1 : raster_y;
    pos_x = x + 1;
    pos_y = y + 1;
    if (x == 0 && y == 0) begin
      least_left      = '0;
      greatest_right  = '0;
      least_top       = '0;
      greatest_bottom = '0;
    end
    if (x == 0) begin
      row_first = '0;
      row_last  = '0;
    end
    fg = (w.red <= white_level) || (w.green <= white_level) || (w.blue <= white_level);
    // row 0 overwrites the column entry, later rows only extend it
    if (y == 0) begin
      col_top[x]    = fg ? 11'(pos_y) : '0;
      col_bottom[x] = fg ? 11'(pos_y) : '0;
    end else if (fg) begin
      if (col_top[x] == '0) col_top[x] = 11'(pos_y);
      col_bottom[x] = 11'(pos_y);
    end
    if (fg) begin
      if (row_first == '0) row_first = 11'(pos_x);
      row_last = 11'(pos_x);
      if (least_top == '0 || pos_y < least_top) least_top = 11'(pos_y);
      if (pos_y > greatest_bottom) greatest_bottom = 11'(pos_y);
    end
    if (pos_x < wd) begin
      raster_x = pos_x;
      raster_y = y;
    end else begin
      if (row_first != '0 && (least_left == '0 || row_first < least_left))
        least_left = row_first;
      if (row_last > greatest_right) greatest_right = row_last;
      profiles_due.push_back(profile_word(KIND_ROW, y, row_first, row_last, pos_y >= ht));
      raster_x = 0;
      raster_y = (pos_y >= ht) ? 0 : pos_y;
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (profiles_due.size() == 0) begin
      fail_count_o++;
      if (reported < 10) begin
        reported++;
        $display("unexpected result word: %s", show(got));
      end
    end else begin
      want = profiles_due.pop_front();
      if (got.result_kind !== want.result_kind || got.line_index !== want.line_index ||
          got.first_edge !== want.first_edge || got.last_edge !== want.last_edge ||
          got.least_left !== want.least_left || got.greatest_right !== want.greatest_right ||
          got.least_top !== want.least_top || got.greatest_bottom !== want.greatest_bottom ||
          got.frame_done !== want.frame_done) begin
        fail_count_o++;
        if (reported < 10) begin
          reported++;
          $display("result mismatch\n  expected %s\n  actual   %s", show(want), show(got));
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_level     = WHITE_LEVEL_RST;
      frame_width     = FRAME_WIDTH_RST;
      frame_height    = FRAME_HEIGHT_RST;
      raster_x        = 0;
      raster_y        = 0;
      row_first       = '0;
      row_last        = '0;
      least_left      = '0;
      greatest_right  = '0;
      least_top       = '0;
      greatest_bottom = '0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        col_top[i]    = '0;
        col_bottom[i] = '0;
      end
      profiles_due.delete();
      pending_o    = 0;
      fail_count_o = 0;
      reported     = 0;
    end else begin
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) check_result(out_data_i);
      if (cfg_valid_i === 1'b1 && cfg_ready_i === 1'b1) begin
        case (cfg_index_i)
          CFG_WHITE_LEVEL:  white_level  = cfg_data_i[7:0];
          CFG_FRAME_WIDTH:  frame_width  = cfg_data_i;
          CFG_FRAME_HEIGHT: frame_height = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        if (in_data_i.req_type == REQ_READ) begin
          profiles_due.push_back(profile_word(KIND_COLUMN, 32'(in_data_i.column_index),
                                              col_top[in_data_i.column_index],
                                              col_bottom[in_data_i.column_index], 1'b0));
        end else begin
          take_pixel(in_data_i);
        end
      end
      pending_o = profiles_due.size();
    end
  end

endmodule

/* tb/tb.sv */
// top of the foreground edge profiler testbench: clock, reset, pixel and read
// stimulus, config writes, output stall and the verdict
// depends on fep_pkg, foreground_edge_profile_top and edge_profile_checker
`timescale 1ns / 100ps

module tb;
  import fep_pkg::*;

  // index 3 is not a register, writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int TOTAL_WORDS = 500;
  // columns written by the early wide row; every later read and pixel stays below
  localparam int COVER_COLS = 48;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_t                  out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int fails;
  int pending;
  int words_sent;     // input words accepted so far
  bit idle_on;        // random gaps and stalls on both channels
  bit long_hold_req;  // asks the receiver for one long stall

  always #4 clk_i = ~clk_i;

  foreground_edge_profile_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  edge_profile_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  // channel value: above the white level (light; 255 if the level is 255) or anything,
  // with the level itself and its neighbor favored
  function automatic logic [7:0] shade(input logic [7:0] level, input bit light);
    if (light) return (level == 8'd255) ? 8'd255 : 8'($urandom_range(int'(level) + 1, 255));
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return level;
      3:       return level + 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_t pix_word(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b);
    in_t w;
    w.req_type     = REQ_PIXEL;
    w.red          = r;
    w.green        = g;
    w.blue         = b;
    w.column_index = 10'($urandom);  // ignored on a pixel
    return w;
  endfunction

  function automatic in_t read_word(input logic [9:0] col);
    in_t w;
    w.req_type     = REQ_READ;
    w.red          = 8'($urandom);   // color fields ignored on a read
    w.green        = 8'($urandom);
    w.blue         = 8'($urandom);
    w.column_index = col;
    return w;
  endfunction

  // read of a random column that has already been written
  function automatic in_t cover_read();
    return read_word(10'($urandom_range(0, COVER_COLS - 1)));
  endfunction

  // about half the pixels are plain background, the rest mostly foreground
  function automatic in_t rand_pixel(input logic [7:0] level);
    bit light;
    light = 1'($urandom_range(0, 1));
    return pix_word(shade(level, light), shade(level, light), shade(level, light));
  endfunction

  // geometry value: mostly small frames, sometimes zero, one or (if allowed)
  // above the maximum
  function automatic logic [10:0] pick_dim(input bit big_ok);
    case ($urandom_range(0, 9))
      0:       return 11'd0;
      1:       return 11'd1;
      2:       return big_ok ? 11'($urandom_range(MAX_WIDTH_DEF + 1, 2047)) : 11'd12;
      default: return 11'($urandom_range(2, 12));
    endcase
  endfunction

  // one word on the input channel; entered and left at a falling edge, valid stays
  // high on exit so back-to-back words never drop it in between
  task automatic send_word(input in_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic set_geometry(input logic [10:0] level_word, input logic [10:0] width,
                              input logic [10:0] height);
    cfg_write(CFG_WHITE_LEVEL, level_word);
    cfg_write(CFG_FRAME_WIDTH, width);
    cfg_write(CFG_FRAME_HEIGHT, height);
    cfg_valid_i <= 1'b0;
  endtask

  // stop sending, wait for every expected word, then let the pipeline empty
  // (a trailing pixel may still be in flight without any result)
  task automatic drain(input int limit);
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (pending != 0 && waited < limit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (6) @(negedge clk_i);
  endtask

  // receiver: short random stall bursts, or one long hold when asked
  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = 60;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        hold_left   = $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] level;
    int         n;
    bit         phase_idle;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_WHITE_LEVEL;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    words_sent    = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: 4 x 2 frames at the default white level
    cfg_write(CFG_SPARE, 11'h7ff);
    set_geometry(11'd250, 11'd4, 11'd2);
    // row 0: red exactly at the level is foreground, 251 is not, blue 0 is
    send_word(pix_word(8'd255, 8'd255, 8'd255));
    send_word(pix_word(8'd250, 8'd255, 8'd255));
    send_word(pix_word(8'd255, 8'd251, 8'd255));
    send_word(pix_word(8'd255, 8'd255, 8'd0));
    // row 1 ends the frame
    send_word(pix_word(8'd0, 8'd0, 8'd0));
    send_word(pix_word(8'd255, 8'd255, 8'd255));
    send_word(pix_word(8'd255, 8'd250, 8'd255));
    send_word(pix_word(8'd255, 8'd255, 8'd255));
    // extremes stay readable after the frame is done; each column has foreground in one row
    for (int c = 0; c < 4; c++) send_word(read_word(10'(c)));
    // second frame: its first pixel clears the extremes, an empty row reports zeros
    repeat (4) send_word(pix_word(8'd255, 8'd255, 8'd255));
    send_word(read_word(10'd3));
    send_word(pix_word(8'd251, 8'd251, 8'd251));
    send_word(pix_word(8'd251, 8'd251, 8'd250));
    send_word(pix_word(8'd255, 8'd255, 8'd255));
    send_word(pix_word(8'd255, 8'd255, 8'd255));
    send_word(read_word(10'd1));
    drain(20000);

    // zero width acts as one: single-pixel rows of a tall frame left unfinished
    set_geometry(11'd0, 11'd0, 11'd2047);
    repeat (20) send_word(rand_pixel(8'd0));
    drain(20000);

    // zero height acts as one, so the unfinished frame restarts at row 0; width
    // above the maximum acts as the maximum, and this partial row writes the
    // column entries that later reads and pixels touch
    set_geometry(11'd255, 11'd2047, 11'd0);
    repeat (COVER_COLS) send_word(rand_pixel(8'd255));
    repeat (12) send_word(cover_read());
    drain(20000);

    // back pressure: the receiver holds off while words keep coming, so the block
    // fills up and stalls its input; then the sender waits for everything to come out
    // (the shrunk width also ends the wide row at its last column)
    set_geometry(11'd250, 11'd6, 11'd4);
    idle_on       = 1'b0;
    long_hold_req = 1'b1;
    repeat (30) send_word(rand_pixel(8'd250));
    drain(20000);
    repeat (20) send_word(($urandom_range(0, 5) == 0) ? cover_read()
                                                      : rand_pixel(8'd250));
    drain(20000);

    // random phases; geometry changes land mid-frame and mid-row too,
    // and the last stretch runs without any idling
    while (words_sent < TOTAL_WORDS) begin
      phase_idle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 4))
        0:       level = 8'd0;
        1:       level = 8'd255;
        default: level = 8'($urandom);
      endcase
      set_geometry({3'($urandom), level}, pick_dim(1'b0), pick_dim(1'b1));
      n = $urandom_range(20, 60);
      repeat (n) begin
        idle_on = phase_idle && (words_sent < TOTAL_WORDS - 100);
        send_word(($urandom_range(0, 6) == 0) ? cover_read() : rand_pixel(level));
      end
      drain(20000);
    end

    drain(5000);
    if (fails == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
